// ----- design/dtq_pkg.sv -----
// Shared types and constants for the deadline timer queue.
package dtq_pkg;
    localparam int unsigned DefSlots = 16;

    localparam logic [1:0] CMD_ADD        = 2'd0;
    localparam logic [1:0] CMD_CANCEL     = 2'd1;
    localparam logic [1:0] CMD_PROCESS    = 2'd2;
    localparam logic [1:0] CMD_CANCEL_ALL = 2'd3;

    localparam logic [2:0] KIND_ADDED  = 3'd0;
    localparam logic [2:0] KIND_FIRED  = 3'd1;
    localparam logic [2:0] KIND_SLICE  = 3'd2;
    localparam logic [2:0] KIND_CANCEL = 3'd3;
    localparam logic [2:0] KIND_FULL   = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] now_ns;
        logic [63:0] deadline_or_delay;
        logic        relative;
        logic [63:0] reload_interval;
        logic [31:0] target_id;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] timer_id;
        logic [63:0] slice_ns;
        logic        last;
    } t_res;

    // Operation select for the shared 64-bit unit
    typedef struct packed {
        logic        sub;   // a - b instead of a + b
    } t_alu_ctl;
endpackage

// ----- design/dtq_if.sv -----
// Valid/ready channel carrying one payload.
interface dtq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/dtq_alu.sv -----
// Shared 64-bit add/subtract unit with an a <= b compare flag.
module dtq_alu
    import dtq_pkg::*;
(
    input  t_alu_ctl    i_ctl,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_y,
    output logic        o_a_le_b
);
    // Add, or subtract when sub is set
    assign o_y      = i_ctl.sub ? (i_a - i_b) : (i_a + i_b);
    assign o_a_le_b = (i_a <= i_b);
endmodule

// ----- design/deadline_timer_queue_core.sv -----
// Top level of the deadline timer queue.
// Commands arrive on i_cmd (valid/ready); results leave on o_res, one
// transaction per result, with last set on the final result of a command.
// A one-bit register, written by i_cfg_we/i_cfg_wdata, makes process
// commands yield: no firing, a slice of zero.
// Add, cancel and cancel-all step once per slot.
// Process scans all slots for the earliest deadline once per firing; a
// cyclic re-arm then checks the new deadline against now (S_REARM) and
// restarts it from now (S_FIX) when it is not after now.
// Each scan walks the slot table with the single shared adder and
// comparator.
// The block takes one command at a time; ready is low while it works.
// Results are held in an output register; a stalled receiver holds the
// block in place until the result is taken.
// Reset (synchronous, active low) empties the table, clears the id counter
// and the yield register; stored ids, deadlines and intervals are not
// cleared and are only read for valid slots.
module deadline_timer_queue_core
    import dtq_pkg::*;
#(
    parameter int unsigned SLOTS = DefSlots
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    dtq_if.sink   i_cmd,
    dtq_if.source o_res
);
    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // walk slots
    localparam logic [2:0] S_FIRE  = 3'd2;  // emit fired, re-arm
    localparam logic [2:0] S_REARM = 3'd3;  // check re-arm is past now
    localparam logic [2:0] S_SLICE = 3'd4;  // compute slice
    localparam logic [2:0] S_OUT   = 3'd5;  // wait for result taken
    localparam logic [2:0] S_FIX   = 3'd6;  // re-arm from now instead

    logic [2:0]      r_state;
    logic            r_yield;
    logic [31:0]     r_idc;
    logic [SLOTS-1:0] r_valid;
    logic [31:0]     r_id  [SLOTS];
    logic [63:0]     r_dl  [SLOTS];
    logic [63:0]     r_iv  [SLOTS];
    t_cmd            r_cmd;
    logic [CW-1:0]   r_idx;
    logic            r_found;
    logic [IW-1:0]   r_best;
    logic [CW-1:0]   r_nfire;
    logic            r_done;   // last result of command pending
    t_res            r_res;
    logic            r_ovalid;

    logic [IW-1:0]   idx;
    t_alu_ctl        alu_ctl;
    logic [63:0]     alu_a, alu_b, alu_y;
    logic            alu_le;
    t_cmd            cmd_in;

    assign idx = r_idx[IW-1:0];

    dtq_alu u_alu (.i_ctl(alu_ctl), .i_a(alu_a), .i_b(alu_b), .o_y(alu_y),
                   .o_a_le_b(alu_le));

    // Route operands to the shared unit by state
    always_comb begin
        alu_ctl.sub = 1'b0;
        alu_a = r_dl[idx];
        alu_b = r_dl[r_best];
        unique case (r_state)
            S_IDLE: begin
                alu_a = i_cmd.data.now_ns;
                alu_b = i_cmd.data.deadline_or_delay;
            end
            S_SCAN: begin
                alu_a = r_dl[r_best];
                alu_b = (r_idx < CW'(SLOTS)) ? r_dl[idx] : r_cmd.now_ns;
            end
            S_FIRE: begin
                alu_a = r_dl[r_best];
                alu_b = r_iv[r_best];
            end
            S_REARM: begin
                alu_a = r_dl[r_best];
                alu_b = r_cmd.now_ns;
            end
            S_SLICE: begin
                alu_ctl.sub = 1'b1;
                alu_a = r_dl[r_best];
                alu_b = r_cmd.now_ns;
            end
            S_FIX: begin
                alu_a = r_cmd.now_ns;
                alu_b = r_iv[r_best];
            end
            default: begin
                alu_a = r_cmd.now_ns;
                alu_b = r_iv[r_best];
            end
        endcase
    end

    // Resolve a relative deadline on the way in
    always_comb begin
        cmd_in = i_cmd.data;
        if (i_cmd.data.relative)
            cmd_in.deadline_or_delay = alu_y;
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;

    // Slot payload: written, never cleared
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_cmd.cmd == CMD_ADD && r_idx < CW'(SLOTS)
            && !r_valid[idx] && !r_done) begin
            r_id[idx] <= r_idc + 32'd1;
            r_iv[idx] <= r_cmd.reload_interval;
            r_dl[idx] <= r_cmd.deadline_or_delay;
        end else if (r_state == S_FIRE && r_iv[r_best] != 64'd0) begin
            r_dl[r_best] <= alu_y;
        end else if (r_state == S_FIX) begin
            r_dl[r_best] <= alu_y;
        end
        if (r_state == S_IDLE && i_cmd.valid)
            r_cmd <= cmd_in;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_yield  <= 1'b0;
            r_idc    <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_best   <= '0;
            r_nfire  <= '0;
            r_done   <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_yield <= i_cfg_wdata;
            if (o_res.valid && o_res.ready)
                r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_nfire <= '0;
                        r_done  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx < CW'(SLOTS)) begin
                        r_idx <= r_idx + CW'(1);
                        unique case (r_cmd.cmd)
                            CMD_ADD: begin
                                if (!r_valid[idx] && !r_done) begin
                                    r_valid[idx] <= 1'b1;
                                    r_idc  <= r_idc + 32'd1;
                                    r_done <= 1'b1;
                                    r_res  <= '{KIND_ADDED, r_idc + 32'd1, 64'd0, 1'b1};
                                end
                            end
                            CMD_CANCEL: begin
                                if (r_valid[idx] && r_id[idx] == r_cmd.target_id)
                                    r_valid[idx] <= 1'b0;
                            end
                            CMD_CANCEL_ALL: r_valid[idx] <= 1'b0;
                            default: begin
                                // earliest valid deadline, lowest slot on ties
                                if (r_valid[idx] && (!r_found || !alu_le)) begin
                                    r_found <= 1'b1;
                                    r_best  <= idx;
                                end
                            end
                        endcase
                    end else begin
                        unique case (r_cmd.cmd)
                            CMD_ADD: begin
                                r_ovalid <= 1'b1;
                                r_state  <= S_OUT;
                                if (!r_done)
                                    r_res <= '{KIND_FULL, 32'd0, 64'd0, 1'b1};
                            end
                            CMD_CANCEL, CMD_CANCEL_ALL: begin
                                r_ovalid <= 1'b1;
                                r_state  <= S_OUT;
                                r_res    <= '{KIND_CANCEL, 32'd0, 64'd0, 1'b1};
                            end
                            default: begin
                                // alu_le: earliest deadline not after now
                                if (r_yield) begin
                                    r_ovalid <= 1'b1;
                                    r_state  <= S_OUT;
                                    r_res    <= '{KIND_SLICE, 32'd0, 64'd0, 1'b1};
                                end else if (r_found && alu_le
                                             && r_nfire < CW'(SLOTS)) begin
                                    r_state <= S_FIRE;
                                end else begin
                                    r_state <= S_SLICE;
                                end
                            end
                        endcase
                    end
                end
                S_FIRE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_res    <= '{KIND_FIRED, r_id[r_best], 64'd0, 1'b0};
                        r_nfire  <= r_nfire + CW'(1);
                        if (r_iv[r_best] == 64'd0) begin
                            r_valid[r_best] <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_REARM;
                        end
                    end
                end
                S_REARM: r_state <= alu_le ? S_FIX : S_OUT;
                S_FIX: r_state <= S_OUT;
                S_SLICE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_done   <= 1'b1;
                        r_res    <= '{KIND_SLICE, 32'd0,
                                      (r_found && !alu_le) ? alu_y : 64'd0, 1'b1};
                        r_state  <= S_OUT;
                    end
                end
                default: begin
                    // wait for the result, then rescan or finish
                    if (!r_ovalid || o_res.ready) begin
                        if (r_cmd.cmd == CMD_PROCESS && !r_yield_done()) begin
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    function automatic logic r_yield_done();
        return r_done || r_res.last;
    endfunction

    // Checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> !o_res.valid) else $error("ready with result pending");
    a_fire_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfire <= CW'(SLOTS)) else $error("fire count over bound");
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> r_state == S_SCAN)
        else $error("accepted command did not start a scan");
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the deadline timer queue core.
module testbench;
    import dtq_pkg::*;

    localparam int unsigned NSLOT = DefSlots;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned NUM_RANDOM = 500;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    dtq_if #(.T(t_cmd)) cmd_ch ();
    dtq_if #(.T(t_res)) res_ch ();

    deadline_timer_queue_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_ch.sink),
        .o_res       (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Model copy of the timer table
    logic        tq_yield;
    logic        tq_valid [NSLOT];
    logic [31:0] tq_id [NSLOT];
    logic [63:0] tq_deadline [NSLOT];
    logic [63:0] tq_interval [NSLOT];
    logic [31:0] tq_next_id;

    t_res expected_results [$];
    int   mismatch_count = 0;
    int   result_count = 0;
    int   fired_count = 0;
    int   full_count = 0;
    int   idle_cycles = 0;
    bit   timed_out = 1'b0;
    bit   hold_sink = 1'b0;
    bit   stim_done = 1'b0;

    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
            if (tq_valid[i] && (best < 0 || tq_deadline[i] < tq_deadline[best])) best = i;
        return best;
    endfunction

    function automatic t_res mk_res(logic [2:0] k, logic [31:0] id, logic [63:0] s,
                                    logic l);
        t_res r;
        r.kind = k;
        r.timer_id = id;
        r.slice_ns = s;
        r.last = l;
        return r;
    endfunction

    // Work out the results of one command and update the table
    task automatic predict_timer_results(input t_cmd c);
        int          free_slot;
        int          n;
        int          top;
        logic [63:0] nd;
        logic [63:0] slice;
        case (c.cmd)
            CMD_ADD: begin
                free_slot = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (!tq_valid[i] && free_slot < 0) free_slot = i;
                if (free_slot < 0) begin
                    expected_results.push_back(mk_res(KIND_FULL, '0, '0, 1'b1));
                end else begin
                    tq_next_id = tq_next_id + 32'd1;
                    tq_valid[free_slot] = 1'b1;
                    tq_id[free_slot] = tq_next_id;
                    tq_deadline[free_slot] = c.relative ? c.now_ns + c.deadline_or_delay
                                                        : c.deadline_or_delay;
                    tq_interval[free_slot] = c.reload_interval;
                    expected_results.push_back(mk_res(KIND_ADDED, tq_next_id, '0, 1'b1));
                end
            end
            CMD_CANCEL: begin
                for (int i = 0; i < NSLOT; i++)
                    if (tq_valid[i] && tq_id[i] == c.target_id) tq_valid[i] = 1'b0;
                expected_results.push_back(mk_res(KIND_CANCEL, '0, '0, 1'b1));
            end
            CMD_CANCEL_ALL: begin
                for (int i = 0; i < NSLOT; i++) tq_valid[i] = 1'b0;
                expected_results.push_back(mk_res(KIND_CANCEL, '0, '0, 1'b1));
            end
            default: begin
                if (tq_yield) begin
                    expected_results.push_back(mk_res(KIND_SLICE, '0, '0, 1'b1));
                end else begin
                    n = 0;
                    top = earliest_slot();
                    while (top >= 0 && tq_deadline[top] <= c.now_ns && n < NSLOT) begin
                        expected_results.push_back(mk_res(KIND_FIRED, tq_id[top], '0, 1'b0));
                        n++;
                        if (tq_interval[top] != '0) begin
                            nd = tq_deadline[top] + tq_interval[top];
                            if (nd <= c.now_ns) nd = c.now_ns + tq_interval[top];
                            tq_deadline[top] = nd;
                        end else begin
                            tq_valid[top] = 1'b0;
                        end
                        top = earliest_slot();
                    end
                    if (top < 0 || tq_deadline[top] <= c.now_ns) slice = '0;
                    else slice = tq_deadline[top] - c.now_ns;
                    expected_results.push_back(mk_res(KIND_SLICE, '0, slice, 1'b1));
                end
            end
        endcase
    endtask

    // Random gap: mostly short, a few long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random command; mostly near a moving time base so that timers fire
    logic [63:0] time_base = 64'd1000;
    logic [31:0] recent_id = 32'd1;

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   r;
        c = '0;
        r = $urandom_range(0, 99);
        c.cmd = (r < 45) ? CMD_ADD : (r < 60) ? CMD_CANCEL : (r < 96) ? CMD_PROCESS
                                                                   : CMD_CANCEL_ALL;
        if ($urandom_range(0, 19) == 0) begin
            c.now_ns = rand64();
            c.deadline_or_delay = rand64();
            c.reload_interval = rand64();
            c.target_id = $urandom();
        end else begin
            c.now_ns = time_base + $urandom_range(0, 200);
            c.deadline_or_delay = $urandom_range(0, 3) == 0 ? time_base + $urandom_range(0, 400)
                                                             : 64'($urandom_range(0, 300));
            c.reload_interval = $urandom_range(0, 2) == 0 ? 64'd0 : 64'($urandom_range(1, 150));
            c.target_id = recent_id - $urandom_range(0, 6);
        end
        c.relative = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic send_cmd(input t_cmd c);
        // valid stays low for at least the cycle after the previous transaction
        repeat (1 + rand_gap()) @(posedge i_clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        cmd_ch.valid <= 1'b0;
        predict_timer_results(c);
        if (c.cmd == CMD_PROCESS) time_base = time_base + $urandom_range(0, 150);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_yield(input logic v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tq_yield = v;
    endtask

    // Receiver: random back-pressure, with an optional long hold-off
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_sink) res_ch.ready <= 1'b0;
            else res_ch.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result kind=%0d id=%0d slice=%0d last=%0d",
                             res_ch.data.kind, res_ch.data.timer_id, res_ch.data.slice_ns,
                             res_ch.data.last);
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.kind == KIND_FIRED) fired_count++;
                if (exp_r.kind == KIND_FULL) full_count++;
                if (res_ch.data !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp kind=%0d id=%0d slice=%0d last=%0d, got kind=%0d id=%0d slice=%0d last=%0d",
                                 exp_r.kind, exp_r.timer_id, exp_r.slice_ns, exp_r.last,
                                 res_ch.data.kind, res_ch.data.timer_id,
                                 res_ch.data.slice_ns, res_ch.data.last);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    typedef struct {
        t_cmd c;
        bit   has_exp;
        t_res r;
    } t_row;

    t_row dir_rows [$];

    function automatic t_cmd mk_cmd(logic [1:0] op, logic [63:0] now, logic [63:0] dd,
                                    logic rel, logic [63:0] iv, logic [31:0] tid);
        t_cmd c;
        c.cmd = op;
        c.now_ns = now;
        c.deadline_or_delay = dd;
        c.relative = rel;
        c.reload_interval = iv;
        c.target_id = tid;
        return c;
    endfunction

    task automatic add_row(input t_cmd c, input bit has_exp, input t_res r);
        t_row row;
        row.c = c;
        row.has_exp = has_exp;
        row.r = r;
        dir_rows.push_back(row);
    endtask

    initial begin
        t_res       none;
        logic [63:0] ones;
        ones = '1;
        none = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        tq_yield = 1'b0;
        tq_next_id = '0;
        for (int i = 0; i < NSLOT; i++) begin
            tq_valid[i] = 1'b0;
            tq_id[i] = '0;
            tq_deadline[i] = '0;
            tq_interval[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty process, extremes, wrap, duplicates
        add_row(mk_cmd(CMD_PROCESS, ones, 0, 0, 0, 0), 1,
                mk_res(KIND_SLICE, 0, 0, 1));
        add_row(mk_cmd(CMD_ADD, 0, 0, 0, 0, 0), 1, mk_res(KIND_ADDED, 1, 0, 1));
        add_row(mk_cmd(CMD_ADD, ones, 64'd5, 1, ones, 0), 1, mk_res(KIND_ADDED, 2, 0, 1));
        add_row(mk_cmd(CMD_ADD, 64'd10, ones, 0, 64'd7, 0), 1, mk_res(KIND_ADDED, 3, 0, 1));
        add_row(mk_cmd(CMD_PROCESS, 64'd20, 0, 0, 0, 0), 0, none);
        add_row(mk_cmd(CMD_CANCEL, 0, 0, 0, 0, 32'hFFFF_FFFF), 1,
                mk_res(KIND_CANCEL, 0, 0, 1));
        add_row(mk_cmd(CMD_CANCEL, 0, 0, 0, 0, 32'd3), 1, mk_res(KIND_CANCEL, 0, 0, 1));
        add_row(mk_cmd(CMD_PROCESS, ones, 0, 0, 0, 0), 0, none);
        add_row(mk_cmd(CMD_CANCEL_ALL, 0, 0, 0, 0, 0), 1, mk_res(KIND_CANCEL, 0, 0, 1));
        for (int i = 0; i < NSLOT; i++)
            add_row(mk_cmd(CMD_ADD, 64'd100, 64'd50, 1, 64'(i % 3), 0), 0, none);
        add_row(mk_cmd(CMD_ADD, 0, 0, 0, 0, 0), 1, mk_res(KIND_FULL, 0, 0, 1));
        add_row(mk_cmd(CMD_PROCESS, ones, 0, 0, 0, 0), 0, none);
        add_row(mk_cmd(CMD_PROCESS, 64'd200, 0, 0, 0, 0), 0, none);
        add_row(mk_cmd(CMD_CANCEL_ALL, 0, 0, 0, 0, 0), 1, mk_res(KIND_CANCEL, 0, 0, 1));

        // Rows with a typed result give a single result, the newest queued
        foreach (dir_rows[k]) begin
            send_cmd(dir_rows[k].c);
            if (dir_rows[k].has_exp && expected_results[$] !== dir_rows[k].r) begin
                mismatch_count++;
                $display("table row %0d disagrees with predictor", k);
            end
        end
        wait_drained();

        // Yielded phase
        write_yield(1'b1);
        send_cmd(mk_cmd(CMD_ADD, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(CMD_PROCESS, ones, 0, 0, 0, 0));
        wait_drained();
        write_yield(1'b0);

        // Long receiver hold-off while commands keep arriving
        fork
            begin
                hold_sink = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_cmd(rand_cmd());
        join

        // Random part, split into phases with different yield settings
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < NUM_RANDOM / 4; i++) begin
                t_cmd c;
                c = rand_cmd();
                send_cmd(c);
                if (c.cmd == CMD_ADD) recent_id = tq_next_id;
            end
            wait_drained();
            write_yield(ph == 1);
        end
        wait_drained();

        $display("covered %0d results, %0d timer firings, %0d table-full rejections",
                 result_count, fired_count, full_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
